FILE: rtl/substitution_cipher_lazy_key_macros.svh
// assertion macros for the substitution cipher block
`ifndef SUBSTITUTION_CIPHER_LAZY_KEY_MACROS_SVH
`define SUBSTITUTION_CIPHER_LAZY_KEY_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SCL_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SCL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scl_pkg.sv
// shared types and constants for the substitution cipher block
`timescale 1ns / 1ps

package scl_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int RANDOM_WIDTH  = 16;

  localparam int BYTE_W   = 8;
  localparam int RND_IN_W = 16;
  localparam int LETTER_W = $clog2(ALPHABET_SIZE);

  localparam logic [BYTE_W-1:0] LETTER_BASE = 8'd97;
  localparam logic [BYTE_W:0]   LETTER_END  = (BYTE_W + 1)'(97 + ALPHABET_SIZE);
  localparam logic [LETTER_W-1:0] POOL_END_RESET = LETTER_W'(ALPHABET_SIZE - 1);

  // remainder unit: bits of the random value consumed per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (RANDOM_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int RND_PAD_W = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_PICK,
    ST_SWAP
  } state_t;

  typedef struct packed {
    logic load;         // input transfer, capture item and start reads
    logic tail_capture; // latch the pool entry at the pool end
    logic div_step;     // one step of the remainder unit
    logic pick_read;    // read the pool at the remainder
    logic emit_lookup;  // result for pass-through or known letter
    logic commit;       // swap, record mapping, result for new letter
  } cmd_t;

  typedef struct packed {
    logic is_letter;
    logic is_mapped;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

FILE: rtl/substitution_cipher_lazy_key.sv
// Lazy-key substitution cipher, top level.
//
// Input channel: plain_byte with random_value, in_valid / in_stall. Output
// channel: cipher_byte with new_mapping, out_valid / out_stall. A transfer
// happens at a clock edge with valid high and stall low.
// Bytes outside the lower-case letter range come back unchanged; a letter
// that already has a key letter gets it again; a new letter draws one from
// the unused pool at random_value mod (pool size).
// One item is in work at a time. Pass-through and known letters raise
// out_valid from the classify state after the input transfer; a new
// letter goes through accept, classify, 4 remainder steps of 4 bits each,
// pool read and swap, and raises out_valid from the swap state.
// The remainder unit and the single read port of the pool ram shape that
// sequence. A new item is taken while the previous result still waits.
// When out_stall holds the result, an item that finishes waits in its last
// state and makes no state change until the result register frees.
// rst (synchronous) empties the key: pool in identity order, no letter
// mapped. in_stall is high during rst; the block is ready the cycle after
// rst falls.
`timescale 1ns / 1ps
`include "substitution_cipher_lazy_key_macros.svh"

module substitution_cipher_lazy_key (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [scl_pkg::BYTE_W-1:0]   plain_byte,
  input  logic [scl_pkg::RND_IN_W-1:0] random_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [scl_pkg::BYTE_W-1:0]   cipher_byte,
  output logic                         new_mapping
);

  scl_pkg::cmd_t    cmd;
  scl_pkg::status_t status;

  scl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  scl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .plain_byte   (plain_byte),
    .random_value (random_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_byte  (cipher_byte),
    .new_mapping  (new_mapping)
  );

  `SCL_ASSERT_IMPLIES(a_new_is_letter, out_valid && new_mapping,
    (cipher_byte >= scl_pkg::LETTER_BASE) &&
    ({1'b0, cipher_byte} < scl_pkg::LETTER_END), "new mapping outside letter range")

  `SCL_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall,
    "second item taken while one is in work")

  `SCL_ASSERT_NEXT(a_commit_result, cmd.commit, out_valid && new_mapping,
    "swap without a new-mapping result")

endmodule

FILE: rtl/scl_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/scl_ctrl.sv
// controller state machine for the substitution cipher block
`timescale 1ns / 1ps

module scl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  scl_pkg::status_t status,
  output scl_pkg::cmd_t    cmd
);

  scl_pkg::state_t state;
  scl_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      scl_pkg::ST_IDLE: begin
        // no transfer while rst is high
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = scl_pkg::ST_CLASSIFY;
        end
      end
      scl_pkg::ST_CLASSIFY: begin
        cmd.tail_capture = 1'b1;
        if (!status.is_letter || status.is_mapped) begin
          if (status.out_free) begin
            cmd.emit_lookup = 1'b1;
            state_next      = scl_pkg::ST_IDLE;
          end
        end else begin
          state_next = scl_pkg::ST_DIV;
        end
      end
      scl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = scl_pkg::ST_PICK;
        end
      end
      scl_pkg::ST_PICK: begin
        cmd.pick_read = 1'b1;
        state_next    = scl_pkg::ST_SWAP;
      end
      scl_pkg::ST_SWAP: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = scl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = scl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/scl_dp.sv
// datapath: letter pool, key map, remainder unit and result register
`timescale 1ns / 1ps

module scl_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  scl_pkg::cmd_t                 cmd,
  output scl_pkg::status_t              status,
  input  logic [scl_pkg::BYTE_W-1:0]    plain_byte,
  input  logic [scl_pkg::RND_IN_W-1:0]  random_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [scl_pkg::BYTE_W-1:0]    cipher_byte,
  output logic                          new_mapping
);

  localparam int LW = scl_pkg::LETTER_W;
  localparam int AS = scl_pkg::ALPHABET_SIZE;

  // input decode
  logic                       in_is_letter;
  logic [scl_pkg::BYTE_W-1:0] in_offset;
  logic [LW-1:0]              in_letter;

  assign in_is_letter = (plain_byte >= scl_pkg::LETTER_BASE) &&
                        ({1'b0, plain_byte} < scl_pkg::LETTER_END);
  assign in_offset    = plain_byte - scl_pkg::LETTER_BASE;
  assign in_letter    = in_offset[LW-1:0];

  // item registers
  logic [scl_pkg::BYTE_W-1:0]    byte_q;
  logic [LW-1:0]                 letter_q;
  logic                          is_letter_q;
  logic [scl_pkg::RND_PAD_W-1:0] rnd_shift;
  logic [LW:0]                   rem;
  logic [LW:0]                   rem_next;
  logic [scl_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [LW-1:0]                 tail_q;

  // key state
  logic [LW-1:0] pool_end;
  logic [AS-1:0] pool_written;
  logic [AS-1:0] mapped;

  // pool ram
  logic          pool_re;
  logic [LW-1:0] pool_raddr;
  logic [LW-1:0] pool_rdata;
  logic [LW-1:0] pool_rd_addr;
  logic          pool_rd_written;
  logic [LW-1:0] pool_word;

  // map ram
  logic          map_re;
  logic [LW-1:0] map_rdata;

  logic [LW-1:0] pick;

  assign pick       = rem[LW-1:0];
  assign pool_re    = cmd.load || cmd.pick_read;
  assign pool_raddr = cmd.pick_read ? pick : pool_end;
  assign map_re     = cmd.load && in_is_letter;

  // an entry never written still holds its own index
  assign pool_word = pool_rd_written ? pool_rdata : pool_rd_addr;

  scl_ram #(
    .WIDTH (LW),
    .DEPTH (AS)
  ) u_pool_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (pick),
    .wdata (tail_q),
    .re    (pool_re),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  scl_ram #(
    .WIDTH (LW),
    .DEPTH (AS)
  ) u_map_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (letter_q),
    .wdata (pool_word),
    .re    (map_re),
    .raddr (in_letter),
    .rdata (map_rdata)
  );

  // remainder of the random value by pool_end + 1, DIV_BITS bits per step
  always_comb begin
    logic [LW:0] divisor;
    logic [LW:0] r;
    divisor = {1'b0, pool_end} + 1'b1;
    r       = rem;
    for (int i = 0; i < scl_pkg::DIV_BITS; i++) begin
      r = {r[LW-1:0], rnd_shift[scl_pkg::RND_PAD_W-1-i]};
      if (r >= divisor) begin
        r = r - divisor;
      end
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q      <= plain_byte;
      letter_q    <= in_letter;
      is_letter_q <= in_is_letter;
      rnd_shift   <= scl_pkg::RND_PAD_W'(random_value[scl_pkg::RANDOM_WIDTH-1:0]);
      rem         <= '0;
      div_cnt     <= '0;
    end else if (cmd.div_step) begin
      rnd_shift <= rnd_shift << scl_pkg::DIV_BITS;
      rem       <= rem_next;
      div_cnt   <= div_cnt + 1'b1;
    end
    if (cmd.tail_capture) begin
      tail_q <= pool_word;
    end
    if (pool_re) begin
      pool_rd_addr    <= pool_raddr;
      pool_rd_written <= pool_written[pool_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_end     <= scl_pkg::POOL_END_RESET;
      pool_written <= '0;
      mapped       <= '0;
    end else if (cmd.commit) begin
      pool_written[pick] <= 1'b1;
      mapped[letter_q]   <= 1'b1;
      if (pool_end != '0) begin
        pool_end <= pool_end - 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_lookup || cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      cipher_byte <= scl_pkg::LETTER_BASE + scl_pkg::BYTE_W'(pool_word);
      new_mapping <= 1'b1;
    end else if (cmd.emit_lookup) begin
      cipher_byte <= is_letter_q ?
                     scl_pkg::LETTER_BASE + scl_pkg::BYTE_W'(map_rdata) : byte_q;
      new_mapping <= 1'b0;
    end
  end

  assign status.is_letter = is_letter_q;
  assign status.is_mapped = is_letter_q && mapped[letter_q];
  assign status.div_last  = (div_cnt == scl_pkg::DIV_CNT_W'(scl_pkg::DIV_STEPS - 1));
  assign status.out_free  = !out_valid || !out_stall;

endmodule
